### design/mat_pkg.sv
// ----------------------------------------------------------------------------
// mat_pkg
// Shared types and constants for the low watermark timestamp tracker.
// ----------------------------------------------------------------------------
package mat_pkg;

    localparam int unsigned DEF_MAX_THREADS = 64;

    localparam int unsigned STAMP_W  = 64;
    localparam int unsigned THREAD_W = 6;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned CFG_W    = 32;

    localparam logic [STAMP_W-1:0] STAMP_NONE = '1;

    localparam logic OP_PUBLISH = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    localparam logic CFG_RECOMPUTE_INTERVAL = 1'b0;
    localparam logic CFG_ACTIVE_THREADS     = 1'b1;

    localparam logic [CFG_W-1:0]   RST_INTERVAL = 32'd1000000;
    localparam logic [COUNT_W-1:0] RST_ACTIVE   = 7'd64;

    // publish broadcast to every cell
    typedef struct packed {
        logic                en;
        logic [THREAD_W-1:0] thread;
        logic [STAMP_W-1:0]  stamp;
    } t_pub;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic               tok;
        logic [STAMP_W-1:0] least;
    } t_scan;

endpackage

### design/mat_cell.sv
// ----------------------------------------------------------------------------
// mat_cell
// One thread entry: takes in-order publishes for its own index and folds
// its entry, if active, into the running minimum as the scan token passes.
// ----------------------------------------------------------------------------
module mat_cell
    import mat_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pub               i_pub,
    input  logic [COUNT_W-1:0] i_count,
    input  t_scan              i_scan,
    output t_scan              o_scan,
    output logic               o_err
);

    logic [STAMP_W-1:0] r_stamp;
    t_scan              r_scan;
    logic               w_hit;
    logic               w_ok;
    logic               w_active;

    assign w_hit    = i_pub.en && (32'(i_pub.thread) == IDX);
    assign w_ok     = (r_stamp == STAMP_NONE) || (i_pub.stamp >= r_stamp);
    assign w_active = 32'(i_count) > IDX;
    assign o_err    = w_hit && !w_ok;
    assign o_scan   = r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp      <= STAMP_NONE;
            r_scan.tok   <= 1'b0;
            r_scan.least <= STAMP_NONE;
        end else begin
            if (w_hit && w_ok) begin
                r_stamp <= i_pub.stamp;
            end
            r_scan.tok <= i_scan.tok;
            if (i_scan.tok && w_active && (r_stamp < i_scan.least)) begin
                r_scan.least <= r_stamp;
            end else begin
                r_scan.least <= i_scan.least;
            end
        end
    end

endmodule

### design/min_active_timestamp_watermark.sv
// ----------------------------------------------------------------------------
// min_active_timestamp_watermark
// Per-thread published timestamps in a row of cells, with a low watermark
// raised by a minimum scan that walks the row one cell per cycle.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  input    | i_in_valid, o_in_stall, operation/thread/...   | in
//  result   | o_out_valid, i_out_stall, watermark/order_error| out
//  config   | i_cfg_we, i_cfg_index, i_cfg_data              | in
//
// A publish or a plain query gives its result in the cycle after acceptance.
// A recomputing query (thread 0, interval elapsed) lasts until the scan token
// crosses every cell of the chain once. One transaction at a time; input
// stalls during a scan and while the result register is full and stalled.
// Reset sets every entry to all ones.
// ----------------------------------------------------------------------------
module min_active_timestamp_watermark
    import mat_pkg::*;
#(
    parameter int unsigned MAX_THREADS = DEF_MAX_THREADS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [THREAD_W-1:0] i_thread,
    input  logic [STAMP_W-1:0]  i_stamp,
    input  logic [STAMP_W-1:0]  i_now,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STAMP_W-1:0]  o_watermark,
    output logic                o_order_error,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic               r_state;
    logic [CFG_W-1:0]   r_interval;
    logic [COUNT_W-1:0] r_active;
    logic [STAMP_W-1:0] r_wm;
    logic [STAMP_W-1:0] r_last;
    logic [STAMP_W-1:0] r_scan_now;
    logic               r_out_valid;
    logic [STAMP_W-1:0] r_out_wm;
    logic               r_out_err;

    logic               w_accept;
    logic               w_recompute;
    logic [COUNT_W-1:0] w_count;
    logic [STAMP_W-1:0] w_elapsed;
    logic               w_done;
    t_pub               w_pub;
    t_scan              w_chain [MAX_THREADS+1];
    logic [MAX_THREADS-1:0] w_err;

    assign o_in_stall  = (r_state == S_SCAN) || (r_out_valid && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_elapsed   = i_now - r_last;
    assign w_recompute = (i_operation == OP_QUERY) && (i_thread == '0)
                         && (w_elapsed > {32'd0, r_interval});
    assign w_done      = w_chain[MAX_THREADS].tok;

    always_comb begin
        w_count = r_active;
        if (r_active == '0) begin
            w_count = COUNT_W'(1);
        end else if (32'(r_active) > MAX_THREADS) begin
            w_count = COUNT_W'(MAX_THREADS);
        end
    end

    assign w_pub = '{en:     w_accept && (i_operation == OP_PUBLISH),
                     thread: i_thread,
                     stamp:  i_stamp};

    assign w_chain[0] = '{tok: w_accept && w_recompute, least: STAMP_NONE};

    for (genvar g = 0; g < MAX_THREADS; g++) begin : g_cell
        mat_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_pub  (w_pub),
            .i_count(w_count),
            .i_scan (w_chain[g]),
            .o_scan (w_chain[g+1]),
            .o_err  (w_err[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= RST_INTERVAL;
            r_active    <= RST_ACTIVE;
            r_wm        <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RECOMPUTE_INTERVAL: r_interval <= i_cfg_data;
                    CFG_ACTIVE_THREADS:     r_active   <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_recompute) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_done) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_last      <= r_scan_now;
                        if (w_chain[MAX_THREADS].least > r_wm) begin
                            r_wm <= w_chain[MAX_THREADS].least;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_scan_now <= i_now;
            r_out_wm   <= r_wm;
            r_out_err  <= |w_err;
        end else if (w_done) begin
            r_out_err <= 1'b0;
            if (w_chain[MAX_THREADS].least > r_wm) begin
                r_out_wm <= w_chain[MAX_THREADS].least;
            end else begin
                r_out_wm <= r_wm;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_watermark   = r_out_wm;
    assign o_order_error = r_out_err;

    a_scan_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> o_in_stall)
        else $error("input accepted during scan");

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_SCAN))
        else $error("scan token left chain outside scan");

    a_wm_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_wm >= $past(r_wm)))
        else $error("watermark fell");

    a_scan_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("result register busy during scan");

endmodule

### tb/watermark_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watermark_checker
// Watches the input, result and register ports of the watermark tracker. It
// keeps its own copy of the per-thread stamp table, the watermark and the
// last scan time, predicts one result per accepted transaction, and compares
// every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module watermark_checker
    import mat_pkg::*;
#(
    parameter int unsigned MAX_THREADS = DEF_MAX_THREADS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_operation,
    input  logic [THREAD_W-1:0] i_thread,
    input  logic [STAMP_W-1:0]  i_stamp,
    input  logic [STAMP_W-1:0]  i_now,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [STAMP_W-1:0]  i_watermark,
    input  logic                i_order_error,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [STAMP_W-1:0] watermark;
        logic               order_error;
    } t_mark;

    logic [STAMP_W-1:0] stamps [MAX_THREADS];
    logic [STAMP_W-1:0] low_mark;
    logic [STAMP_W-1:0] last_scan_time;
    logic [CFG_W-1:0]   scan_interval;
    logic [COUNT_W-1:0] active_count;
    t_mark              mark_q [$];
    int                 fails = 0;

    task automatic report_mismatch(input string what);
        fails++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // applies one transaction to the tracked state, returns what the block must give
    function automatic t_mark track_item(input logic op, input logic [THREAD_W-1:0] thread,
                                         input logic [STAMP_W-1:0] stamp,
                                         input logic [STAMP_W-1:0] now);
        t_mark              res;
        logic [STAMP_W-1:0] held;
        logic [STAMP_W-1:0] least;
        int                 span;
        res.order_error = 1'b0;
        if (op == OP_PUBLISH) begin
            if (thread < MAX_THREADS) begin
                held = stamps[thread];
                if (held == STAMP_NONE || stamp >= held) begin
                    stamps[thread] = stamp;
                end else begin
                    res.order_error = 1'b1;
                end
            end
        end else if (thread == 0 && (now - last_scan_time) > scan_interval) begin
            // zero active counts as one, oversize saturates
            span = (active_count == 0) ? 1 :
                   ((active_count > MAX_THREADS) ? MAX_THREADS : active_count);
            least = STAMP_NONE;
            for (int k = 0; k < span; k++) begin
                if (stamps[k] < least) least = stamps[k];
            end
            if (least > low_mark) low_mark = least;
            last_scan_time = now;
        end
        res.watermark = low_mark;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_mark want;
        if (!i_rst_n) begin
            foreach (stamps[k]) stamps[k] = STAMP_NONE;
            low_mark       = '0;
            last_scan_time = '0;
            scan_interval  = RST_INTERVAL;
            active_count   = RST_ACTIVE;
            mark_q.delete();
        end else begin
            // result first: it can only belong to an earlier transaction
            if (i_out_valid && !i_out_stall) begin
                if (mark_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, watermark %h order_error %b",
                                              i_watermark, i_order_error));
                end else begin
                    want = mark_q.pop_front();
                    if (i_watermark !== want.watermark)
                        report_mismatch($sformatf("watermark %h, expected %h",
                                                  i_watermark, want.watermark));
                    if (i_order_error !== want.order_error)
                        report_mismatch($sformatf("order_error %b, expected %b",
                                                  i_order_error, want.order_error));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RECOMPUTE_INTERVAL: scan_interval = i_cfg_data;
                    CFG_ACTIVE_THREADS:     active_count  = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                mark_q.push_back(track_item(i_operation, i_thread, i_stamp, i_now));
        end
        o_pending    <= mark_q.size();
        o_fail_count <= fails;
    end

endmodule

### tb/tb_min_active_timestamp_watermark.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_active_timestamp_watermark
// Drives publish and query transactions into the watermark tracker: a
// directed opening at reset settings, then random phases under several
// register settings with bursty input and a patterned result stall. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_min_active_timestamp_watermark;
    import mat_pkg::*;

    localparam int unsigned THREADS     = DEF_MAX_THREADS;
    localparam int          TAIL_CYCLES = THREADS + 16;
    localparam logic [STAMP_W-1:0] HALF_STAMP = {1'b1, {(STAMP_W-1){1'b0}}};

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} t_stall_kind;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic                operation  = OP_PUBLISH;
    logic [THREAD_W-1:0] thread     = '0;
    logic [STAMP_W-1:0]  stamp      = '0;
    logic [STAMP_W-1:0]  now        = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [STAMP_W-1:0]  watermark;
    logic                order_error;
    logic                cfg_we     = 1'b0;
    logic                cfg_index  = CFG_RECOMPUTE_INTERVAL;
    logic [CFG_W-1:0]    cfg_data   = '0;

    int                  fail_count;
    int                  results_due;

    logic [STAMP_W-1:0]  last_pub [THREADS];
    logic [STAMP_W-1:0]  sim_now;
    int                  burst_left = 0;
    t_stall_kind         stall_kind = STALL_NONE;
    int                  stall_left = 0;

    min_active_timestamp_watermark #(.MAX_THREADS(THREADS)) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (operation),
        .i_thread      (thread),
        .i_stamp       (stamp),
        .i_now         (now),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_watermark   (watermark),
        .o_order_error (order_error),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    watermark_checker #(.MAX_THREADS(THREADS)) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_operation   (operation),
        .i_thread      (thread),
        .i_stamp       (stamp),
        .i_now         (now),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_watermark   (watermark),
        .i_order_error (order_error),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (results_due)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side stalls in segments: none, light, heavy or solid
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_kind = t_stall_kind'($urandom_range(0, 3));
            stall_left = (stall_kind == STALL_SOLID) ? $urandom_range(1, 30)
                                                     : $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_kind)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= 1'b1;
        endcase
    end

    function automatic logic [STAMP_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one transaction, with a random gap before each burst
    task automatic offer_item(input logic op, input logic [THREAD_W-1:0] th,
                              input logic [STAMP_W-1:0] st, input logic [STAMP_W-1:0] nw);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid  <= 1'b1;
        operation <= op;
        thread    <= th;
        stamp     <= st;
        now       <= nw;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic drain;
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (results_due != 0);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] interval, input logic [COUNT_W-1:0] active);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RECOMPUTE_INTERVAL;
        cfg_data  <= interval;
        @(posedge clk);
        cfg_index <= CFG_ACTIVE_THREADS;
        cfg_data  <= {{(CFG_W-COUNT_W){1'b0}}, active};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wild: publishes may carry arbitrary 64-bit stamps
    task automatic run_phase(input logic [CFG_W-1:0] interval, input logic [COUNT_W-1:0] active,
                             input int count, input bit wild);
        int                  span;
        int unsigned         adv;
        int unsigned         pick;
        logic [THREAD_W-1:0] th;
        logic [STAMP_W-1:0]  st;
        logic [STAMP_W-1:0]  nw;
        logic [STAMP_W-1:0]  base;
        logic [STAMP_W-1:0]  jump;
        drain();
        write_regs(interval, active);
        span = (active == 0) ? 1 : ((active > THREADS) ? THREADS : active);
        adv  = interval / 8 + 1;
        for (int n = 0; n < count; n++) begin
            jump = STAMP_W'(adv);
            if ($urandom_range(0, 9) == 0) sim_now += jump * $urandom_range(1, 24);
            else                           sim_now += $urandom_range(0, adv);
            pick = $urandom_range(0, 99);
            th   = ($urandom_range(0, 9) < 7) ? THREAD_W'($urandom_range(0, span - 1))
                                              : THREAD_W'($urandom_range(0, THREADS - 1));
            if (pick < 70) begin
                if (pick >= 67 && wild) begin
                    st = rand64();
                end else if (pick >= 63) begin
                    st = STAMP_NONE;
                end else if (pick >= 55) begin
                    // goes backwards unless the entry was cleared
                    st = (last_pub[th] > 100) ? last_pub[th] - $urandom_range(1, 100) : '0;
                end else begin
                    base = (last_pub[th] > sim_now) ? last_pub[th] : sim_now;
                    st   = base + $urandom_range(0, 40);
                end
                if (st != STAMP_NONE && st > last_pub[th]) last_pub[th] = st;
                offer_item(OP_PUBLISH, th, st, rand64());
            end else begin
                if ($urandom_range(0, 3) != 0) th = '0;
                pick = $urandom_range(0, 9);
                if (pick < 8)       nw = sim_now;
                else if (pick == 8) nw = sim_now - $urandom_range(0, adv);
                else                nw = rand64();
                offer_item(OP_QUERY, th, rand64(), nw);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening at reset settings
        offer_item(OP_PUBLISH, 6'd0,  64'd0,      rand64());
        offer_item(OP_PUBLISH, 6'd63, STAMP_NONE, rand64());
        offer_item(OP_PUBLISH, 6'd1,  64'd500,    rand64());
        offer_item(OP_PUBLISH, 6'd1,  64'd499,    rand64());  // backwards, flagged
        offer_item(OP_PUBLISH, 6'd1,  64'd500,    rand64());  // equal is fine
        offer_item(OP_PUBLISH, 6'd0,  STAMP_NONE, rand64());  // clears thread 0
        offer_item(OP_PUBLISH, 6'd2,  64'd600,    rand64());
        offer_item(OP_QUERY,   6'd7,  rand64(),   STAMP_NONE);  // not thread 0
        offer_item(OP_QUERY,   6'd0,  rand64(),   64'd1000000); // exactly the interval
        offer_item(OP_QUERY,   6'd0,  rand64(),   64'd1000001); // first scan
        offer_item(OP_PUBLISH, 6'd1,  64'd400,    rand64());
        offer_item(OP_PUBLISH, 6'd2,  STAMP_NONE, rand64());
        offer_item(OP_QUERY,   6'd0,  rand64(),   64'd5);       // time went back
        offer_item(OP_PUBLISH, 6'd1,  64'd800,    rand64());
        offer_item(OP_QUERY,   6'd0,  rand64(),   64'd1000005);
        offer_item(OP_QUERY,   6'd0,  rand64(),   64'd1000006);
        offer_item(OP_PUBLISH, 6'd0,  64'd700,    rand64());
        offer_item(OP_QUERY,   6'd0,  rand64(),   STAMP_NONE);  // min below mark, no drop
        offer_item(OP_QUERY,   6'd0,  rand64(),   64'd1000000); // wraps past all ones
        offer_item(OP_PUBLISH, 6'd5,  HALF_STAMP, rand64());
        offer_item(OP_PUBLISH, 6'd5,  STAMP_NONE, rand64());
        offer_item(OP_QUERY,   6'd63, rand64(),   64'd0);

        foreach (last_pub[k]) last_pub[k] = 64'd1000;
        sim_now = 64'd2000000;

        run_phase(32'd0,          7'd1,   250, 1'b0);
        run_phase(32'hFFFF_FFFF,  7'd64,  300, 1'b0);
        run_phase(32'd37,         7'd0,   250, 1'b0);
        run_phase(32'd5000,       7'd127, 300, 1'b0);
        run_phase($urandom_range(1, 200000), 7'($urandom_range(1, 64)), 300, 1'b0);
        run_phase(RST_INTERVAL,   RST_ACTIVE, 400, 1'b1);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
